FILE: rtl/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types, constants and the CRC-8 step for the packet frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  // Largest payload length that is accepted without a too-big status.
  localparam int unsigned MAX_PAYLOAD = 32;

  localparam logic [7:0] SOF_VALUE_RST = 8'd213;

  // Reflected CRC-8 polynomial (Dallas/Maxim).
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Opcodes of the input channel.
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_CRC_BAD = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       packet_done;
    logic [1:0] status_code;
    logic [7:0] received_count;
    logic [2:0] parser_phase;
  } out_item_t;

  // One byte of the running CRC, processed LSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/packet_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// packet_frame_receiver_unit
// Parses start byte, length, payload and CRC-8 of length-prefixed frames.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries one byte of the
//   serial stream per transfer, or a restart opcode that clears the parser.
//   Every input transfer produces exactly one result transfer on the output
//   channel (out_valid/out_ready/out_data): payload bytes below the size
//   limit come out with their index, together with phase, status and count.
//   The cfg channel writes the start byte value; it is always ready and
//   should only be written while no result is outstanding.
//   The result is registered. Throughput is one item per cycle while the
//   receiver takes each result: parser state and output register update in
//   the same edge, and the CRC byte step is a short combinational chain.
//   A result that the receiver stalls stays in the output register and
//   in_ready drops until it is taken; no item is lost or repeated.
//   Reset (rst_n low, synchronous) returns the parser to waiting for a
//   start byte, clears count, CRC and status, empties the output register
//   and restores the start byte to its default.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_frame_receiver_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire pfr_pkg::in_item_t in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output pfr_pkg::out_item_t out_data,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [7:0]        cfg_data
);

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC     = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  localparam logic [7:0] MAX_LEN = 8'(pfr_pkg::MAX_PAYLOAD);

  phase_t             phase_r, phase_nxt;
  logic [7:0]         exp_len_r, exp_len_nxt;
  logic [7:0]         byte_cnt_r, byte_cnt_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [7:0]         sof_value_r;
  logic               out_valid_r;
  pfr_pkg::out_item_t out_data_r, out_data_nxt;
  logic               in_xfer;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    phase_nxt    = phase_r;
    exp_len_nxt  = exp_len_r;
    byte_cnt_nxt = byte_cnt_r;
    crc_nxt      = crc_r;
    status_nxt   = status_r;
    out_data_nxt = '0;

    if (in_data.opcode == pfr_pkg::OP_RESTART) begin
      phase_nxt    = PH_WAIT;
      exp_len_nxt  = '0;
      byte_cnt_nxt = '0;
      crc_nxt      = '0;
      status_nxt   = pfr_pkg::ST_OK;
    end else begin
      unique case (phase_r)
        PH_WAIT: begin
          if (in_data.data_byte == sof_value_r) begin
            phase_nxt    = PH_LEN;
            exp_len_nxt  = '0;
            byte_cnt_nxt = '0;
            crc_nxt      = '0;
            status_nxt   = pfr_pkg::ST_OK;
          end
        end
        PH_LEN: begin
          exp_len_nxt  = in_data.data_byte;
          byte_cnt_nxt = '0;
          phase_nxt    = PH_PAYLOAD;
          if (in_data.data_byte > MAX_LEN) begin
            status_nxt = pfr_pkg::ST_TOO_BIG;
          end
        end
        PH_PAYLOAD: begin
          // A zero length falls straight through: the byte is swallowed.
          if (byte_cnt_r < exp_len_r) begin
            crc_nxt = pfr_pkg::crc8_step(crc_r, in_data.data_byte);
            if (byte_cnt_r < MAX_LEN) begin
              out_data_nxt.payload_valid = 1'b1;
              out_data_nxt.payload_byte  = in_data.data_byte;
              out_data_nxt.payload_index = byte_cnt_r;
            end
            byte_cnt_nxt = byte_cnt_r + 8'd1;
          end
          if (byte_cnt_nxt >= exp_len_r) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          if (crc_r != in_data.data_byte) begin
            status_nxt = pfr_pkg::ST_CRC_BAD;
          end
          phase_nxt = PH_DONE;
        end
        default: begin
          // Finished: hold until a restart arrives.
        end
      endcase
    end

    out_data_nxt.packet_done    = (phase_nxt == PH_DONE);
    out_data_nxt.status_code    = status_nxt;
    out_data_nxt.received_count = byte_cnt_nxt;
    out_data_nxt.parser_phase   = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      exp_len_r   <= '0;
      byte_cnt_r  <= '0;
      crc_r       <= '0;
      status_r    <= pfr_pkg::ST_OK;
      sof_value_r <= pfr_pkg::SOF_VALUE_RST;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sof_value_r <= cfg_data;
      end
      if (in_xfer) begin
        phase_r    <= phase_nxt;
        exp_len_r  <= exp_len_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        crc_r      <= crc_nxt;
        status_r   <= status_nxt;
        out_data_r <= out_data_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The count never runs past the announced length.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= exp_len_r)
    else $error("byte count exceeds expected length");

  // An emitted payload byte comes from the payload phase and lies below the limit.
  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.payload_valid |->
      (out_data_r.parser_phase == PH_PAYLOAD || out_data_r.parser_phase == PH_CRC) &&
      out_data_r.payload_index < MAX_LEN)
    else $error("payload result outside payload phase or limit");

  // Done flag agrees with the reported phase.
  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.packet_done == (out_data_r.parser_phase == PH_DONE))
    else $error("packet_done disagrees with phase");

  // A stalled result blocks new input so it cannot be overwritten.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // Parser state only moves on an input transfer.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(phase_r) && $stable(byte_cnt_r) && $stable(crc_r))
    else $error("parser state changed without input transfer");

endmodule

`default_nettype wire
